/* rtl/dodq_pkg.sv */
// Shared types and codes for the deadline ordered dispatch queue.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package dodq_pkg;

	// Command codes of an input item
	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_DISPATCH = 2'd1,
		CMD_COMPLETE = 2'd2
	} dodq_cmd_t;

	// Status codes of a result item
	typedef enum logic [2:0] {
		STS_ADDED      = 3'd0,
		STS_REJ_DRAIN  = 3'd1,
		STS_REJ_FULL   = 3'd2,
		STS_DISPATCHED = 3'd3,
		STS_NONE       = 3'd4,
		STS_COMPLETED  = 3'd5,
		STS_UNEXPECTED = 3'd6
	} dodq_status_t;

	localparam int unsigned KeyW = 32;
	localparam int unsigned DlW  = 48;
	localparam int unsigned IdW  = 32;
	localparam int unsigned OccW = 5;

	// Object payload held by one cell
	typedef struct packed {
		logic [KeyW-1:0] key;
		logic            hd;
		logic [DlW-1:0]  dl;
	} dodq_item_t;

	typedef struct packed {
		logic       valid;
		dodq_item_t item;
	} dodq_entry_t;

	// What a cell shows to its neighbors
	typedef struct packed {
		dodq_entry_t e;
		logic        ahead;
		logic        match;
	} dodq_link_t;

	// Broadcast control from the sequencer to all cells
	typedef struct packed {
		logic       capture;
		dodq_item_t cmp_item;
		logic       ins;
		logic       pop;
		logic       found;
		dodq_item_t ins_item;
	} dodq_ctl_t;

endpackage

`default_nettype wire

/* rtl/dodq_if.sv */
// Handshake interfaces for the command and result channels of the queue.
// Depends on dodq_pkg for field widths.
`default_nettype none

interface dodq_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 command;
	logic [dodq_pkg::KeyW-1:0]  object_key;
	logic                       has_deadline;
	logic [dodq_pkg::DlW-1:0]   deadline;
	logic [dodq_pkg::IdW-1:0]   transfer_id;

	modport source (output valid, command, object_key, has_deadline, deadline, transfer_id,
		input ready);
	modport sink (input valid, command, object_key, has_deadline, deadline, transfer_id,
		output ready);
endinterface

interface dodq_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 status;
	logic [dodq_pkg::KeyW-1:0]  out_key;
	logic                       out_has_deadline;
	logic [dodq_pkg::DlW-1:0]   out_deadline;
	logic [dodq_pkg::OccW-1:0]  occupancy;

	modport source (output valid, status, out_key, out_has_deadline, out_deadline, occupancy,
		input ready);
	modport sink (input valid, status, out_key, out_has_deadline, out_deadline, occupancy,
		output ready);
endinterface

`default_nettype wire

/* rtl/dodq_cell.sv */
// One slot of the sorted queue: holds an entry, compares it against the
// incoming object and picks its next entry from itself, a neighbor or the inserted object. Uses dodq_pkg.
`default_nettype none

module dodq_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  dodq_pkg::dodq_ctl_t  ctl,
	input  dodq_pkg::dodq_link_t prev,
	input  dodq_pkg::dodq_link_t next,
	input  wire                 prev_lt,
	output logic                lt,
	output dodq_pkg::dodq_link_t cur
);
	import dodq_pkg::*;

	logic       valid_q;
	dodq_item_t item_q;
	logic       ahead_q;
	logic       match_q;
	logic       ahead_c;
	logic       ahead_p;
	dodq_item_t src;
	dodq_item_t ins_norm;

	// Match lies strictly after this slot while no match seen so far
	assign lt = prev_lt & ~match_q;

	assign cur.e.valid = valid_q;
	assign cur.e.item  = item_q;
	assign cur.ahead   = ahead_q;
	assign cur.match   = match_q;

	// Pick the entry for this slot after removing the match and inserting
	always_comb begin
		ins_norm    = ctl.ins_item;
		ins_norm.dl = ctl.ins_item.hd ? ctl.ins_item.dl : '0;
		ahead_c     = lt ? ahead_q : next.ahead;
		ahead_p     = prev_lt ? prev.ahead : ahead_q;
		if (ahead_c) begin
			src = lt ? item_q : next.e.item;
		end else if (ahead_p) begin
			src = ins_norm;
		end else begin
			src = prev_lt ? prev.e.item : item_q;
		end
	end

	// Occupancy of the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next.e.valid;
		end else if (ctl.ins) begin
			valid_q <= ctl.found ? valid_q : (valid_q | prev.e.valid);
		end
	end

	// Payload and compare flags
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			match_q <= valid_q && (item_q.key == ctl.cmp_item.key);
			ahead_q <= valid_q && (!ctl.cmp_item.hd ||
				(item_q.hd && (item_q.dl <= ctl.cmp_item.dl)));
		end
		if (ctl.pop) begin
			item_q <= next.e.item;
		end else if (ctl.ins) begin
			item_q <= src;
		end
	end

endmodule

`default_nettype wire

/* rtl/deadline_ordered_dispatch_queue.sv */
// Deadline ordered dispatch queue: a row of QUEUE_DEPTH sorted cells and a sequencer.
// The command transfer captures the compare flags of the cell row, then the shift cycle
// updates the row and loads the result register; a new command is taken only after that.
// A stalled result holds the shift cycle until the result register frees up.
// arst_n clears the table, the in-flight mark, draining and the result valid.
// Depends on dodq_pkg, dodq_if and dodq_cell.
`default_nettype none

module deadline_ordered_dispatch_queue #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_we,
	input  wire            cfg_wdata,
	dodq_cmd_if.sink       cmd,
	dodq_rsp_if.source     rsp
);
	import dodq_pkg::*;

	localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t           state_q;
	logic             draining_q;
	logic             in_flight_q;
	logic [KeyW-1:0]  if_key_q;
	logic [IdW-1:0]   if_id_q;
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  count_next;
	logic [CntW+OccW-1:0] occ_ext;

	logic [1:0]       cmd_s1;
	dodq_item_t       item_s1;
	logic [IdW-1:0]   tid_s1;

	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [KeyW-1:0]  out_key_q;
	logic             out_hd_q;
	logic [DlW-1:0]   out_dl_q;
	logic [OccW-1:0]  occ_q;

	dodq_ctl_t        ctl;
	dodq_link_t       links [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] lt_vec;
	logic [QUEUE_DEPTH-1:0] match_vec;
	dodq_link_t       head_edge;
	dodq_link_t       tail_edge;

	logic             accept;
	logic             commit;
	logic             found;
	logic             do_ins;
	logic             do_pop;
	logic             do_done;
	dodq_status_t     status_d;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign commit    = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);
	assign found     = ~lt_vec[QUEUE_DEPTH-1];

	// Edge links: the slot before the head acts as a valid entry ahead of all
	always_comb begin
		head_edge         = '0;
		head_edge.e.valid = 1'b1;
		head_edge.ahead   = 1'b1;
		tail_edge         = '0;
	end

	// Decide the outcome of the held command
	always_comb begin
		do_ins   = 1'b0;
		do_pop   = 1'b0;
		do_done  = 1'b0;
		status_d = STS_NONE;
		case (cmd_s1)
			CMD_ADD: begin
				if (draining_q) begin
					status_d = STS_REJ_DRAIN;
				end else if (!found && (count_q == CntW'(QUEUE_DEPTH))) begin
					status_d = STS_REJ_FULL;
				end else begin
					status_d = STS_ADDED;
					do_ins   = 1'b1;
				end
			end
			CMD_DISPATCH: begin
				if (links[0].e.valid && !in_flight_q) begin
					status_d = STS_DISPATCHED;
					do_pop   = 1'b1;
				end
			end
			CMD_COMPLETE: begin
				if (in_flight_q && (tid_s1 == if_id_q)) begin
					status_d = STS_COMPLETED;
					do_done  = 1'b1;
				end else begin
					status_d = STS_UNEXPECTED;
				end
			end
			default: status_d = STS_NONE;
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (do_ins && !found) begin
			count_next = count_q + 1'b1;
		end else if (do_pop) begin
			count_next = count_q - 1'b1;
		end
		occ_ext = {{OccW{1'b0}}, count_next};
	end

	// Broadcast to the cell row
	always_comb begin
		ctl.capture  = accept;
		ctl.cmp_item.key = cmd.object_key;
		ctl.cmp_item.hd  = cmd.has_deadline;
		ctl.cmp_item.dl  = cmd.deadline;
		ctl.ins      = commit && do_ins;
		ctl.pop      = commit && do_pop;
		ctl.found    = found;
		ctl.ins_item = item_s1;
	end

	// Row of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		dodq_link_t prev_l;
		dodq_link_t next_l;
		logic       prev_lt;
		if (i == 0) begin : g_first
			assign prev_l  = head_edge;
			assign prev_lt = 1'b1;
		end else begin : g_mid
			assign prev_l  = links[i-1];
			assign prev_lt = lt_vec[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_l = tail_edge;
		end else begin : g_inner
			assign next_l = links[i+1];
		end
		dodq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.prev    (prev_l),
			.next    (next_l),
			.prev_lt (prev_lt),
			.lt      (lt_vec[i]),
			.cur     (links[i])
		);
		assign match_vec[i] = links[i].match;
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			draining_q  <= 1'b0;
			in_flight_q <= 1'b0;
			if_key_q    <= '0;
			if_id_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				draining_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
				if (do_pop) begin
					in_flight_q <= 1'b1;
					if_key_q    <= links[0].e.item.key;
					if_id_q     <= tid_s1;
				end else if (do_done) begin
					in_flight_q <= 1'b0;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the command payload and load the result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= cmd.command;
			item_s1.key  <= cmd.object_key;
			item_s1.hd   <= cmd.has_deadline;
			item_s1.dl   <= cmd.deadline;
			tid_s1       <= cmd.transfer_id;
		end
		if (commit) begin
			status_q  <= status_d;
			out_key_q <= do_pop ? links[0].e.item.key : (do_done ? if_key_q : '0);
			out_hd_q  <= do_pop && links[0].e.item.hd;
			out_dl_q  <= (do_pop && links[0].e.item.hd) ? links[0].e.item.dl : '0;
			occ_q     <= occ_ext[OccW-1:0];
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = status_q;
	assign rsp.out_key          = out_key_q;
	assign rsp.out_has_deadline = out_hd_q;
	assign rsp.out_deadline     = out_dl_q;
	assign rsp.occupancy        = occ_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(QUEUE_DEPTH))
		else $error("pending count beyond queue depth");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $onehot0(match_vec))
		else $error("key present in more than one slot");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		links[0].e.valid == (count_q != '0))
		else $error("head slot validity disagrees with pending count");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && !commit |=> (state_q == S_EXEC) && $stable(count_q))
		else $error("table changed while the result register was blocked");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the deadline ordered dispatch queue: sorted adds, dispatch, completion.
// A scoreboard class predicts every result; plain tasks drive the command and config ports.
// Depends on dodq_pkg, dodq_if and the deadline_ordered_dispatch_queue top level.
`timescale 1ns / 1ps

module tb_top;
	import dodq_pkg::*;

	localparam int unsigned DEPTH        = 16;
	localparam logic [1:0]  CMD_RESERVED = 2'd3;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          LIMIT_CYCLES = 400000;

	// One result as the block reports it
	typedef struct packed {
		logic [2:0]      status;
		logic [KeyW-1:0] key;
		logic            hd;
		logic [DlW-1:0]  dl;
		logic [OccW-1:0] occ;
	} result_t;

	// Predicts the sorted table and the in-flight mark; holds results still to come
	class queue_scoreboard;
		dodq_item_t      pending[$];
		result_t         awaited[$];
		bit              busy;
		logic [KeyW-1:0] busy_key;
		logic [IdW-1:0]  busy_id;
		bit              draining;
		int              errors;

		function void set_draining(bit v);
			draining = v;
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function void note_command(logic [1:0] op, logic [KeyW-1:0] key, logic hd,
				logic [DlW-1:0] dl, logic [IdW-1:0] tid);
			result_t    r;
			dodq_item_t it;
			int         idx;
			int         pos;
			r = '0;
			r.status = STS_NONE;
			case (op)
				CMD_ADD: begin
					idx = -1;
					foreach (pending[i])
						if (pending[i].key == key) idx = i;
					if (draining) begin
						r.status = STS_REJ_DRAIN;
					end else if (idx < 0 && pending.size() >= DEPTH) begin
						r.status = STS_REJ_FULL;
					end else begin
						// drop the old entry of this key, then insert in deadline order
						if (idx >= 0) pending.delete(idx);
						it.key = key;
						it.hd = hd;
						it.dl = hd ? dl : '0;
						pos = pending.size();
						if (hd) begin
							pos = 0;
							while (pos < pending.size() && pending[pos].hd && pending[pos].dl <= dl)
								pos++;
						end
						pending.insert(pos, it);
						r.status = STS_ADDED;
					end
				end
				CMD_DISPATCH: begin
					if (pending.size() > 0 && !busy) begin
						it = pending[0];
						pending.delete(0);
						r.key = it.key;
						r.hd = it.hd;
						r.dl = it.hd ? it.dl : '0;
						busy = 1'b1;
						busy_key = it.key;
						busy_id = tid;
						r.status = STS_DISPATCHED;
					end
				end
				CMD_COMPLETE: begin
					if (busy && tid == busy_id) begin
						busy = 1'b0;
						r.key = busy_key;
						r.status = STS_COMPLETED;
					end else begin
						r.status = STS_UNEXPECTED;
					end
				end
				default: r.status = STS_NONE;
			endcase
			r.occ = OccW'(pending.size());
			awaited.insert(awaited.size(), r);
		endfunction

		function void field_check(string name, logic [63:0] e, logic [63:0] a);
			if (a !== e) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with none pending, expected nothing, actual %0h",
					$time, got);
				return;
			end
			e = awaited[0];
			awaited.delete(0);
			field_check("status", 64'(e.status), 64'(got.status));
			field_check("out_key", 64'(e.key), 64'(got.key));
			field_check("out_has_deadline", 64'(e.hd), 64'(got.hd));
			field_check("out_deadline", 64'(e.dl), 64'(got.dl));
			field_check("occupancy", 64'(e.occ), 64'(got.occ));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	dodq_cmd_if cmd_ch();
	dodq_rsp_if rsp_ch();

	deadline_ordered_dispatch_queue #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	queue_scoreboard sb = new();

	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int tx_burst      = 0;
	int rx_burst      = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	int hold_cnt      = 0;
	int cycle_count   = 0;

	// Clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result side: check each transfer, then pick ready for the next cycle
	always @(posedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready)
			sb.check_result({rsp_ch.status, rsp_ch.out_key, rsp_ch.out_has_deadline,
				rsp_ch.out_deadline, rsp_ch.occupancy});
		if (hold_cnt > 0) begin
			hold_cnt--;
			if (hold_cnt == 0) holds_served++;
			rsp_ch.ready <= 1'b0;
		end else if (holds_served != hold_requests) begin
			hold_cnt = HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (rx_burst > 0) begin
			rx_burst--;
			rsp_ch.ready <= 1'b1;
		end else begin
			if ($urandom_range(0, 99) < 3) rx_burst = $urandom_range(10, 40);
			rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// Offer one command, with random gaps, and hold it until its transfer
	task automatic send_item(logic [1:0] op, logic [KeyW-1:0] key, logic hd,
			logic [DlW-1:0] dl, logic [IdW-1:0] tid);
		if (tx_burst > 0) begin
			tx_burst--;
		end else begin
			if ($urandom_range(0, 99) < 3) tx_burst = $urandom_range(10, 40);
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= op;
		cmd_ch.object_key   <= key;
		cmd_ch.has_deadline <= hd;
		cmd_ch.deadline     <= dl;
		cmd_ch.transfer_id  <= tid;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		sb.note_command(op, key, hd, dl, tid);
	endtask

	// Stop offering until every result is back, then let the block settle
	task automatic pause_until_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_draining(bit v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_draining(v);
	endtask

	// Mostly keys already queued or from a small pool, so replacements happen often
	function automatic logic [KeyW-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40 && sb.pending.size() > 0)
			return sb.pending[$urandom_range(0, sb.pending.size() - 1)].key;
		if (r < 75) return $urandom_range(0, 31);
		if (r < 95) return $urandom;
		return (r < 97) ? '0 : '1;
	endfunction

	// Small deadlines give many ties; the rest spans the whole range
	function automatic logic [DlW-1:0] pick_deadline();
		logic [DlW-1:0] d;
		int             r;
		r = $urandom_range(0, 99);
		d = DlW'({$urandom, $urandom});
		if (r < 30) d = DlW'($urandom_range(0, 7));
		else if (r < 40) d = '1;
		else if (r < 50) d = '0;
		return d;
	endfunction

	// Random traffic; the add share swings so the table fills up and empties again
	task automatic run_random(int count);
		int             add_pct;
		int             roll;
		logic [1:0]     op;
		logic [IdW-1:0] tid;
		add_pct = 20;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) pause_until_drained();
			if (i % 60 == 0) add_pct = (add_pct == 60) ? 20 : 60;
			roll = $urandom_range(0, 99);
			tid = $urandom;
			if (roll < 2) begin
				op = CMD_RESERVED;
			end else if (roll < add_pct) begin
				op = CMD_ADD;
			end else if (roll < add_pct + (100 - add_pct) / 2) begin
				op = CMD_DISPATCH;
			end else begin
				op = CMD_COMPLETE;
				if (sb.busy && $urandom_range(0, 99) < 85) tid = sb.busy_id;
			end
			send_item(op, pick_key(), $urandom_range(0, 99) < 70, pick_deadline(), tid);
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = CMD_ADD;
		cmd_ch.object_key   = '0;
		cmd_ch.has_deadline = 1'b0;
		cmd_ch.deadline     = '0;
		cmd_ch.transfer_id  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_draining(1'b0);

		// Directed: empty table, unexpected completion, reserved command
		send_item(CMD_DISPATCH, '0, 1'b0, '0, 32'h1234);
		send_item(CMD_COMPLETE, '0, 1'b0, '0, '0);
		send_item(CMD_RESERVED, '1, 1'b1, '1, '1);
		// Order: no deadline last, zero deadline first, equal deadlines by arrival
		send_item(CMD_ADD, '0, 1'b0, '1, '0);
		send_item(CMD_ADD, '1, 1'b1, '1, '0);
		send_item(CMD_ADD, 32'd5, 1'b1, '0, '0);
		send_item(CMD_ADD, 32'd6, 1'b1, '1, '0);
		// Same key again: replace
		send_item(CMD_ADD, '0, 1'b1, 48'd10, '0);
		// Dispatch, dispatch while in flight, wrong id, then the right one
		send_item(CMD_DISPATCH, '0, 1'b0, '0, '1);
		send_item(CMD_DISPATCH, '0, 1'b0, '0, 32'd7);
		send_item(CMD_COMPLETE, '0, 1'b0, '0, '0);
		send_item(CMD_COMPLETE, '0, 1'b0, '0, '1);
		// Fill the table, overflow once, then replace a key while full
		for (int i = 0; i < 14; i++)
			send_item(CMD_ADD, 32'd100 + i, i[0], 48'd20 - i, '0);
		send_item(CMD_ADD, 32'd100, 1'b1, 48'd1, '0);
		pause_until_drained();

		// Draining: adds rejected, dispatch still served
		write_draining(1'b1);
		send_item(CMD_ADD, 32'd200, 1'b1, 48'd3, '0);
		send_item(CMD_DISPATCH, '0, 1'b0, '0, 32'hA5A5_5A5A);
		send_item(CMD_COMPLETE, '0, 1'b0, '0, 32'hA5A5_5A5A);
		pause_until_drained();
		write_draining(1'b0);

		// Random phases over the idling modes
		for (int m = 0; m < 4; m++) begin
			tx_idle_pct  = (m == 1) ? 65 : (m == 3) ? 35 : 0;
			rx_stall_pct = (m == 2) ? 65 : (m == 3) ? 35 : 0;
			if (m == 0) hold_requests++;
			run_random(450);
			pause_until_drained();
			if (m == 2) begin
				write_draining(1'b1);
				run_random(100);
				pause_until_drained();
				write_draining(1'b0);
			end
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
